@@ hw/rtl/lrumc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrumc_pkg
// Shared sizes, codes and cell-chain types for the lru cache miss counter.
// ----------------------------------------------------------------------------
package lrumc_pkg;

    localparam int MAX_WAYS  = 64;
    localparam int ADDR_BITS = 32;
    localparam int CAP_W     = 7;
    localparam int MISS_W    = 32;

    localparam int IDX_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RANK_W = IDX_W;
    localparam int LIM_W  = RANK_W + 1;
    localparam int FILL_W = $clog2(MAX_WAYS + 1);
    localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;

    localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(64);
    localparam logic [RANK_W-1:0] RANK_MAX  = RANK_W'(MAX_WAYS - 1);
    localparam logic [LIM_W-1:0]  LIMIT_ALL = LIM_W'(MAX_WAYS);

    localparam logic ACT_ACCESS = 1'b0;
    localparam logic ACT_REPORT = 1'b1;

    // lookup token that walks down the row of cells
    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic                 hit;
        logic [IDX_W-1:0]     hit_idx;
        logic [RANK_W-1:0]    hit_rank;
        logic                 found;
        logic [RANK_W-1:0]    best_rank;
        logic [IDX_W-1:0]     best_idx;
    } tok_t;

    // update broadcast to every cell
    typedef struct packed {
        logic                 en;
        logic                 fill;
        logic [IDX_W-1:0]     way;
        logic [LIM_W-1:0]     limit;
        logic [ADDR_BITS-1:0] addr;
    } upd_t;

endpackage

@@ hw/rtl/lrumc_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrumc_cfg_if
// Capacity register write channel.
// ----------------------------------------------------------------------------
interface lrumc_cfg_if;

    logic                        valid;
    logic                        ready;
    logic [lrumc_pkg::CAP_W-1:0] capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);

endinterface

@@ hw/rtl/lrumc_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrumc_req_if
// Request channel: access or report items.
// ----------------------------------------------------------------------------
interface lrumc_req_if;

    logic                            valid;
    logic                            ready;
    logic                            action;
    logic [lrumc_pkg::ADDR_BITS-1:0] address;

    modport source (output valid, output action, output address, input ready);
    modport sink   (input valid, input action, input address, output ready);

endinterface

@@ hw/rtl/lrumc_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrumc_rsp_if
// Result channel: hit flag, miss count and report flag.
// ----------------------------------------------------------------------------
interface lrumc_rsp_if;

    logic                         valid;
    logic                         ready;
    logic                         was_hit;
    logic [lrumc_pkg::MISS_W-1:0] miss_count;
    logic                         is_report;

    modport source (output valid, output was_hit, output miss_count, output is_report,
                    input ready);
    modport sink   (input valid, input was_hit, input miss_count, input is_report,
                    output ready);

endinterface

@@ hw/rtl/lrumc_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrumc_cell
// One cache way: holds tag, valid and recency rank, folds its own match and
// victim candidacy into the passing token, and applies the update broadcast.
// ----------------------------------------------------------------------------
module lrumc_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [lrumc_pkg::IDX_W-1:0]  index,
    input  logic [lrumc_pkg::FILL_W-1:0] cap,
    input  lrumc_pkg::tok_t              tok_in,
    output lrumc_pkg::tok_t              tok_out,
    input  lrumc_pkg::upd_t              upd
);
    import lrumc_pkg::*;

    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic                 valid_reg, valid_next;
    logic [RANK_W-1:0]    rank_reg, rank_next;
    tok_t                 tok_reg, tok_next;
    logic                 in_use;
    logic                 match;
    logic                 cand;
    logic                 age;

    always_comb
    begin
        in_use = FILL_W'(index) < cap;
        match  = in_use && valid_reg && (addr_reg == tok_in.addr);
        cand   = in_use && valid_reg && (!tok_in.found || (rank_reg > tok_in.best_rank));

        tok_next = tok_in;
        // first match in index order wins
        if (!tok_in.hit && match)
        begin
            tok_next.hit      = 1'b1;
            tok_next.hit_idx  = index;
            tok_next.hit_rank = rank_reg;
        end
        // strictly larger rank replaces, so ties keep the lower index
        if (cand)
        begin
            tok_next.found     = 1'b1;
            tok_next.best_rank = rank_reg;
            tok_next.best_idx  = index;
        end
    end

    always_comb
    begin
        age        = valid_reg && ({1'b0, rank_reg} < upd.limit) && (rank_reg != RANK_MAX);
        addr_next  = addr_reg;
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (upd.en)
        begin
            if (upd.way == index)
            begin
                rank_next = '0;
                if (upd.fill)
                begin
                    addr_next  = upd.addr;
                    valid_next = 1'b1;
                end
            end
            else if (age)
            begin
                rank_next = rank_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        tok_reg  <= tok_next;
    end

    assign tok_out = tok_reg;

endmodule

@@ hw/rtl/lru_cache_miss_counter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_cache_miss_counter
// Fully associative lru cache model that counts misses, built as a row of
// way cells walked by a lookup token.
// ----------------------------------------------------------------------------
// Items are handled one at a time. For an access item the lookup token moves
// through the row of way cells one cell per cycle, collecting the first
// matching way and the oldest way in use; the update state then broadcasts the
// recency and fill update to all cells, and the done state hands the result to
// the output register, waiting while that register is full and not taken. A
// report item goes straight to the done state. The output register lets the
// next item be accepted while a result still waits to be taken. Capacity
// writes are taken at any time and must only be made while the block is idle.
module lru_cache_miss_counter (
    input  logic        clk,
    input  logic        rst_n,
    lrumc_cfg_if.sink   cfg,
    lrumc_req_if.sink   req,
    lrumc_rsp_if.source rsp
);
    import lrumc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [FILL_W-1:0] filled_reg, filled_next;
    logic [MISS_W-1:0] misses_reg, misses_next;
    logic [CAP_W-1:0]  capacity_reg, capacity_next;
    tok_t              seed_reg, seed_next;
    logic              pend_hit_reg, pend_hit_next;
    logic [MISS_W-1:0] pend_miss_reg, pend_miss_next;
    logic              pend_rep_reg, pend_rep_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_hit_reg, out_hit_next;
    logic [MISS_W-1:0] out_miss_reg, out_miss_next;
    logic              out_rep_reg, out_rep_next;

    tok_t              chain [MAX_WAYS+1];
    tok_t              res;
    upd_t              upd;
    logic [FILL_W-1:0] cap_eff;
    logic [CMP_W-1:0]  cap_ext;
    logic              acc;
    logic              fill_free;
    logic              out_load;
    logic [MISS_W-1:0] misses_inc;

    // capacity 0 acts as 1, above the built size acts as the built size
    always_comb
    begin
        cap_ext = CMP_W'(capacity_reg);
        if (capacity_reg == '0)
            cap_eff = FILL_W'(1);
        else if (cap_ext > CMP_W'(MAX_WAYS))
            cap_eff = FILL_W'(MAX_WAYS);
        else
            cap_eff = FILL_W'(capacity_reg);
    end

    assign chain[0] = seed_reg;
    assign res      = chain[MAX_WAYS];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_WAYS; gi++)
        begin : g_way
            lrumc_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .index   (IDX_W'(gi)),
                .cap     (cap_eff),
                .tok_in  (chain[gi]),
                .tok_out (chain[gi+1]),
                .upd     (upd)
            );
        end
    endgenerate

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign acc       = req.valid && req.ready;
    assign fill_free = filled_reg < cap_eff;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);
    assign misses_inc = (misses_reg == '1) ? misses_reg : misses_reg + 1'b1;

    always_comb
    begin
        upd.en    = (state_reg == S_UPD);
        upd.fill  = !res.hit;
        upd.limit = res.hit ? {1'b0, res.hit_rank} : LIMIT_ALL;
        upd.addr  = seed_reg.addr;
        if (res.hit)
            upd.way = res.hit_idx;
        else if (fill_free)
            upd.way = IDX_W'(filled_reg);
        else if (res.found)
            upd.way = res.best_idx;
        else
            upd.way = '0;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        filled_next    = filled_reg;
        misses_next    = misses_reg;
        seed_next      = seed_reg;
        pend_hit_next  = pend_hit_reg;
        pend_miss_next = pend_miss_reg;
        pend_rep_next  = pend_rep_reg;
        capacity_next  = (cfg.valid && cfg.ready) ? cfg.capacity : capacity_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (req.action == ACT_REPORT)
                    begin
                        pend_hit_next  = 1'b0;
                        pend_miss_next = misses_reg;
                        pend_rep_next  = 1'b1;
                        misses_next    = '0;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        seed_next      = '0;
                        seed_next.addr = req.address;
                        cnt_next       = '0;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // move to the update state once the token has left the last cell
                if (cnt_reg == IDX_W'(MAX_WAYS - 1))
                    state_next = S_UPD;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_UPD:
            begin
                if (!res.hit)
                begin
                    misses_next = misses_inc;
                    if (fill_free)
                        filled_next = filled_reg + 1'b1;
                end
                pend_hit_next  = res.hit;
                pend_miss_next = res.hit ? misses_reg : misses_inc;
                pend_rep_next  = 1'b0;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_hit_next   = out_hit_reg;
        out_miss_next  = out_miss_reg;
        out_rep_next   = out_rep_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_hit_next   = pend_hit_reg;
            out_miss_next  = pend_miss_reg;
            out_rep_next   = pend_rep_reg;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            filled_reg    <= '0;
            misses_reg    <= '0;
            capacity_reg  <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            filled_reg    <= filled_next;
            misses_reg    <= misses_next;
            capacity_reg  <= capacity_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seed_reg      <= seed_next;
        pend_hit_reg  <= pend_hit_next;
        pend_miss_reg <= pend_miss_next;
        pend_rep_reg  <= pend_rep_next;
        out_hit_reg   <= out_hit_next;
        out_miss_reg  <= out_miss_next;
        out_rep_reg   <= out_rep_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.was_hit    = out_hit_reg;
    assign rsp.miss_count = out_miss_reg;
    assign rsp.is_report  = out_rep_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> (state_reg == S_SCAN) || (state_reg == S_DONE))
        else $error("block not busy after accepting an item");

    a_report_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (req.action == ACT_REPORT)) |=> (misses_reg == '0))
        else $error("miss count not cleared by report");

    a_fill_advances: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_UPD) && !res.hit && fill_free)
        |=> (filled_reg == FILL_W'($past(filled_reg) + 1'b1)))
        else $error("fill count did not advance on a fill");

    a_miss_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        ((misses_reg == '1) && !acc) |=> (misses_reg == '1))
        else $error("saturated miss count changed without a report");

    a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) |-> (FILL_W'(filled_reg) <= FILL_W'(MAX_WAYS)))
        else $error("fill count beyond the number of ways");

endmodule
